// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SWR_ASSERT_IMPLY(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);
`define SWR_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SWR_ASSERT_IMPLY(lbl, ck, rs, ante, cons, msg)
`define SWR_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

// ===== rtl/core/swr_pkg.sv =====
// ----------------------------------------------------------------------------
// swr_pkg
// Shared types and constants of the sliding-window reorder receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package swr_pkg;

  localparam int MAGIC_W = 32;
  localparam int SEQ_W   = 31;
  localparam int LEN_W   = 11;
  localparam int TAG_W   = 16;
  localparam int NUM_W   = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_HIGH,
    ST_DLV,
    ST_WALK,
    ST_ACK
  } state_t;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  // register select is paddr[2]
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_MAGIC  = 1'b1;

  localparam logic [4:0]         WINDOW_RESET = 5'd10;
  localparam logic [MAGIC_W-1:0] MAGIC_RESET  = '0;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] len;
  } slot_t;

endpackage

`default_nettype wire

// ===== rtl/core/swr_if.sv =====
// ----------------------------------------------------------------------------
// swr_if
// Valid/ready channels for packet descriptors and receiver results.
// ----------------------------------------------------------------------------
`default_nettype none

interface swr_in_if;
  logic                        valid;
  logic                        ready;
  logic [swr_pkg::MAGIC_W-1:0] magic;
  logic [swr_pkg::SEQ_W-1:0]   sequence_req;
  logic [swr_pkg::LEN_W-1:0]   length;
  logic                        eof;
  logic [swr_pkg::TAG_W-1:0]   payload_tag;

  modport source (output valid, magic, sequence_req, length, eof, payload_tag,
                  input ready);
  modport sink (input valid, magic, sequence_req, length, eof, payload_tag,
                output ready);
endinterface

interface swr_out_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [swr_pkg::TAG_W-1:0]        out_tag;
  logic [swr_pkg::LEN_W-1:0]        out_length;
  logic signed [swr_pkg::NUM_W-1:0] ack_number;
  logic                             ack_eof;
  logic                             complete;
  logic                             last;

  modport source (output valid, kind, out_tag, out_length, ack_number, ack_eof,
                  complete, last, input ready);
  modport sink (input valid, kind, out_tag, out_length, ack_number, ack_eof,
                complete, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sliding_window_reorder_receiver.sv =====
// ----------------------------------------------------------------------------
// sliding_window_reorder_receiver
// Selective-repeat receiver: window check, reorder ring, delivery walk, ack.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one packet descriptor per item; tx carries results (in-order
//   deliveries, then at most one cumulative ack), the final one marked last.
//   The APB port sets window_size (0x0) and magic_value (0x4); write it only
//   while no item is in flight.
//   An item is taken in the idle state; then the window is checked, the high
//   mark is updated, each in-order packet is delivered (the held one first,
//   then the walk over the ring) and the ack is settled, in that order.
//   One shared 33-bit subtractor does the window compare, the high-mark
//   compare and the ack number in turn; the reorder ring is read one slot
//   per cycle while tx is not stalled.
//   A dropped item (wrong magic or out of window) yields no result; the
//   block returns from the window check straight to idle.
//   Reset clears next_expected, the high mark and all slot flags; slot
//   contents need no clearing pass.
//   A stalled tx holds the result in the output register and the walk waits;
//   a new item is taken once the walk is done, even with a result pending.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sliding_window_reorder_receiver #(
  parameter int WINDOW_MAX = 16,
  parameter int MAX_LEN    = 1500
) (
  input  logic        clk,
  input  logic        rst,
  swr_in_if.sink      rx,
  swr_out_if.source   tx,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int DW = $clog2(WINDOW_MAX + 1);
  localparam int CW = (DW > 5) ? DW : 5;
  localparam int SW = ((DW > IW) ? DW : IW) + 1;
  localparam int AW = swr_pkg::NUM_W + 1;

  localparam logic [CW-1:0] WIN_CAP  = CW'(WINDOW_MAX);
  localparam logic [DW-1:0] N_MAX    = DW'(WINDOW_MAX);
  localparam logic [SW-1:0] W_SLOT   = SW'(WINDOW_MAX);
  localparam logic [IW-1:0] HEAD_TOP = IW'(WINDOW_MAX - 1);
  localparam logic [15:0]   LEN_CAP  = 16'(MAX_LEN);

  // configuration
  logic [4:0]                  window_size;
  logic [swr_pkg::MAGIC_W-1:0] magic_value;
  logic                        cfg_wr;

  // control state
  swr_pkg::state_t             state, state_next;
  logic [swr_pkg::NUM_W-1:0]   next_expected;
  logic [swr_pkg::NUM_W-1:0]   highest_plus_one;
  logic [IW-1:0]               head, head_next;
  logic [DW-1:0]               n_cnt;
  logic [WINDOW_MAX-1:0]       slot_valid;
  logic                        dlv_req;

  // held item
  logic [swr_pkg::MAGIC_W-1:0] it_magic;
  logic [swr_pkg::SEQ_W-1:0]   it_seq;
  logic [swr_pkg::LEN_W-1:0]   it_len;
  logic                        it_eof;
  logic [swr_pkg::TAG_W-1:0]   it_tag;
  logic [swr_pkg::LEN_W-1:0]   sat_len;

  // reorder ring
  swr_pkg::slot_t              slot_mem [WINDOW_MAX];
  swr_pkg::slot_t              rd_data;

  // shared subtractor
  logic [AW-1:0]               alu_a, alu_b, alu_res;

  logic [CW-1:0]               win_eff;
  logic                        below, above, pass, ahead, at_head;
  logic [SW-1:0]               slot_sum, slot_wrap;
  logic [IW-1:0]               slot_idx;
  logic                        park_we;
  logic                        seq_ge_high;

  logic                        out_free;
  logic [IW-1:0]               head_inc;
  logic [swr_pkg::NUM_W-1:0]   nr_inc;
  logic [DW-1:0]               n_inc;
  logic                        more, gap_open, walk_end, ack_send;
  logic                        emit_dlv, emit_ack;
  logic [swr_pkg::TAG_W-1:0]   dlv_tag;
  logic [swr_pkg::LEN_W-1:0]   dlv_len;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == swr_pkg::REG_WINDOW) ? {27'd0, window_size} : magic_value;

  // ---------------------------------------------------------------- datapath
  always_comb begin
    unique case (state)
      swr_pkg::ST_RANGE: begin
        alu_a = {2'b00, it_seq};
        alu_b = {1'b0, next_expected};
      end
      swr_pkg::ST_HIGH: begin
        alu_a = {2'b00, it_seq};
        alu_b = {1'b0, highest_plus_one};
      end
      default: begin
        alu_a = {1'b0, next_expected};
        alu_b = AW'(1);
      end
    endcase
  end

  assign alu_res = alu_a - alu_b;

  assign win_eff = (CW'(window_size) > WIN_CAP) ? WIN_CAP : CW'(window_size);
  // seq - nr below -1 or at/above the window drops the item
  assign below   = alu_res[AW-1] && (alu_res != {AW{1'b1}});
  assign above   = !alu_res[AW-1] && (alu_res >= AW'(win_eff));
  assign pass    = (it_magic == magic_value) && !below && !above;
  assign at_head = pass && (alu_res == '0);
  assign ahead   = pass && !alu_res[AW-1] && (alu_res != '0);

  // ring slot of an early packet: head plus its distance, wrapped once
  assign slot_sum  = SW'(head) + SW'(alu_res[DW-1:0]);
  assign slot_wrap = (slot_sum >= W_SLOT) ? (slot_sum - W_SLOT) : slot_sum;
  assign slot_idx  = slot_wrap[IW-1:0];
  assign park_we   = (state == swr_pkg::ST_RANGE) && ahead && !slot_valid[slot_idx];

  assign seq_ge_high = !alu_res[AW-1];

  assign sat_len = ({5'd0, rx.length} > LEN_CAP) ? LEN_CAP[swr_pkg::LEN_W-1:0] : rx.length;

  assign out_free = !tx.valid || tx.ready;
  assign head_inc = (head == HEAD_TOP) ? '0 : head + IW'(1);
  assign nr_inc   = next_expected + 32'd1;
  assign n_inc    = n_cnt + DW'(1);
  // peek at the following slot so the final delivery can carry last
  assign more     = (n_inc != N_MAX) && slot_valid[head_inc];
  assign gap_open = it_eof && (highest_plus_one != nr_inc);
  assign walk_end = (n_cnt == N_MAX) || !slot_valid[head];
  assign ack_send = !it_eof || (highest_plus_one == next_expected);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      swr_pkg::ST_IDLE:  if (rx.valid) state_next = swr_pkg::ST_RANGE;
      swr_pkg::ST_RANGE: state_next = pass ? swr_pkg::ST_HIGH : swr_pkg::ST_IDLE;
      swr_pkg::ST_HIGH:  state_next = dlv_req ? swr_pkg::ST_DLV : swr_pkg::ST_ACK;
      swr_pkg::ST_DLV:   if (out_free) state_next = swr_pkg::ST_WALK;
      swr_pkg::ST_WALK:  if (walk_end) state_next = swr_pkg::ST_ACK;
      swr_pkg::ST_ACK:   if (!ack_send || out_free) state_next = swr_pkg::ST_IDLE;
      default:           state_next = swr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rx.ready = 1'b0;
    emit_dlv = 1'b0;
    emit_ack = 1'b0;
    dlv_tag  = it_tag;
    dlv_len  = it_len;
    unique case (state)
      swr_pkg::ST_IDLE: rx.ready = 1'b1;
      swr_pkg::ST_DLV:  emit_dlv = out_free;
      swr_pkg::ST_WALK: begin
        emit_dlv = out_free && !walk_end;
        dlv_tag  = rd_data.tag;
        dlv_len  = rd_data.len;
      end
      swr_pkg::ST_ACK:  emit_ack = out_free && ack_send;
      default: ;
    endcase
  end

  assign head_next = emit_dlv ? head_inc : head;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= swr_pkg::ST_IDLE;
      window_size      <= swr_pkg::WINDOW_RESET;
      magic_value      <= swr_pkg::MAGIC_RESET;
      next_expected    <= '0;
      highest_plus_one <= '0;
      head             <= '0;
      n_cnt            <= '0;
      slot_valid       <= '0;
      dlv_req          <= 1'b0;
      tx.valid         <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      if (cfg_wr) begin
        if (paddr[2] == swr_pkg::REG_WINDOW) begin
          window_size <= pwdata[4:0];
        end else begin
          magic_value <= pwdata;
        end
      end
      if (state == swr_pkg::ST_RANGE) begin
        dlv_req <= at_head;
      end
      if (park_we) begin
        slot_valid[slot_idx] <= 1'b1;
      end
      if (state == swr_pkg::ST_HIGH) begin
        n_cnt <= '0;
        if (seq_ge_high) begin
          highest_plus_one <= {1'b0, it_seq} + 32'd1;
        end
      end
      if (emit_dlv) begin
        next_expected <= nr_inc;
        n_cnt         <= n_inc;
        // free the slot just delivered from the ring
        if (state == swr_pkg::ST_WALK) begin
          slot_valid[head] <= 1'b0;
        end
      end
      if (emit_dlv || emit_ack) begin
        tx.valid <= 1'b1;
      end else if (tx.ready) begin
        tx.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      it_magic <= rx.magic;
      it_seq   <= rx.sequence_req;
      it_len   <= sat_len;
      it_eof   <= rx.eof;
      it_tag   <= rx.payload_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (park_we) begin
      slot_mem[slot_idx] <= '{tag: it_tag, len: it_len};
    end
    rd_data <= slot_mem[head_next];
  end

  always_ff @(posedge clk) begin
    if (emit_dlv) begin
      tx.kind       <= swr_pkg::KIND_DELIVER;
      tx.out_tag    <= dlv_tag;
      tx.out_length <= dlv_len;
      tx.ack_number <= '0;
      tx.ack_eof    <= 1'b0;
      tx.complete   <= 1'b0;
      tx.last       <= !more && gap_open;
    end else if (emit_ack) begin
      tx.kind       <= swr_pkg::KIND_ACK;
      tx.out_tag    <= '0;
      tx.out_length <= '0;
      tx.ack_number <= $signed(alu_res[swr_pkg::NUM_W-1:0]);
      tx.ack_eof    <= it_eof;
      tx.complete   <= it_eof;
      tx.last       <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- checks
  `SWR_ASSERT_IMPLY(a_park_off_head, clk, rst, park_we, slot_idx != head, "park hit head slot")
  `SWR_ASSERT_IMPLY(a_head_empty, clk, rst, state == swr_pkg::ST_IDLE, !slot_valid[head], "head slot left valid")
  `SWR_ASSERT_NEXT(a_nr_step, clk, rst, 1'b1, next_expected == $past(next_expected) || next_expected == $past(next_expected) + 32'd1, "next_expected jumped")
  `SWR_ASSERT_NEXT(a_high_mono, clk, rst, 1'b1, highest_plus_one >= $past(highest_plus_one), "high mark fell")

endmodule

`default_nettype wire
